// ----- src/dtd_pkg.sv -----
// ----------------------------------------------------------------------------
// dtd_pkg
// shared types, constants and calendar helpers for the date/time adder
// ----------------------------------------------------------------------------
package dtd_pkg;

	localparam int BASE_YEAR_DEF      = 2000;
	localparam int YEAR_SPAN_DEF      = 100;
	localparam int MAX_TRIP_HOURS_DEF = 1023;

	localparam int IN_W   = 64;
	localparam int OUT_W  = 40;
	localparam int SUB_W  = 11;
	localparam int DAY_W  = 7;
	localparam int Y400_W = 9;

	localparam logic [SUB_W-1:0] SEC_PER_MIN = 11'd60;
	localparam logic [SUB_W-1:0] MIN_PER_HR  = 11'd60;
	localparam logic [SUB_W-1:0] HR_PER_DAY  = 11'd24;
	localparam logic [Y400_W-1:0] Y400_LAST  = 9'd399;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [4:0] SAT_DAY    = 5'd31;
	localparam logic [4:0] SAT_HOUR   = 5'd23;
	localparam logic [5:0] SAT_MINUTE = 6'd59;
	localparam logic [5:0] SAT_SECOND = 6'd59;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEAP,
		S_CLAMP,
		S_SEC,
		S_MIN,
		S_HOUR,
		S_WALK,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SEC,
		OP_MIN,
		OP_HOUR,
		OP_DAY
	} op_t;

	typedef struct packed {
		logic in_ready;
		logic leap_ld;
		logic clamp_ld;
		op_t  op;
		logic out_ld;
	} ctrl_t;

	typedef struct packed {
		logic ge;
		logic gt;
		logic ovf_next;
		logic bit_last;
		logic out_free;
	} stat_t;

	// year position inside the 400-year cycle
	function automatic logic is_leap(input logic [Y400_W-1:0] y400);
		is_leap = (y400[1:0] == 2'd0) && (y400 != 9'd100) &&
			(y400 != 9'd200) && (y400 != 9'd300);
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
		logic [3:0] idx;
		idx = month - 4'd1;
		if (month == MONTH_FEB) begin
			days_in = leap ? 5'd29 : 5'd28;
		end else if (idx < 4'd12) begin
			days_in = MONTH_LEN[idx];
		end else begin
			days_in = 5'd31;
		end
	endfunction

endpackage

// ----- src/datetime_duration_adder.sv -----
// ----------------------------------------------------------------------------
// datetime_duration_adder
// adds a trip duration to a departure date and time, gregorian calendar
// ----------------------------------------------------------------------------
// the shared subtract unit steps through the seconds and minutes carries,
// six hour-division steps, and one month per cycle in the day walk;
// input not ready while busy, so a new word is taken only after the last
// result is loaded into the output register
// reset: asynchronous, clears sequencer and output valid, no clearing pass
// ----------------------------------------------------------------------------
module datetime_duration_adder #(
	parameter int BASE_YEAR      = dtd_pkg::BASE_YEAR_DEF,
	parameter int YEAR_SPAN      = dtd_pkg::YEAR_SPAN_DEF,
	parameter int MAX_TRIP_HOURS = dtd_pkg::MAX_TRIP_HOURS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// dep_year, dep_month, dep_day, dep_hour, dep_minute, dep_second,
	// trip_hours, trip_minutes, trip_seconds
	input  logic [dtd_pkg::IN_W-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// arr_year, arr_month, arr_day, arr_hour, arr_minute, arr_second, year_overflow
	output logic [dtd_pkg::OUT_W-1:0] m_tdata
);

	import dtd_pkg::*;

	localparam logic [11:0] YEAR_FIRST = 12'(BASE_YEAR);
	localparam logic [11:0] YEAR_LAST  = 12'(BASE_YEAR + YEAR_SPAN - 1);
	localparam logic [9:0]  BASE_MOD   = 10'(BASE_YEAR % 400);

	logic [11:0] in_year;
	logic [3:0]  in_month;
	logic [4:0]  in_day;
	logic [4:0]  in_hour;
	logic [5:0]  in_minute;
	logic [5:0]  in_second;
	logic [9:0]  in_th;
	logic [5:0]  in_tm;
	logic [5:0]  in_ts;
	logic [11:0] year_c;
	logic [3:0]  month_c;
	logic [9:0]  th_c;

	logic [11:0]       year_q;
	logic [Y400_W-1:0] y400_q;
	logic [3:0]        month_q;
	logic [DAY_W-1:0]  day_q;
	logic [6:0]        sec_q;
	logic [7:0]        min_q;
	logic [SUB_W-1:0]  hr_q;
	logic [2:0]        k_q;
	logic              ovf_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	ctrl_t  ctrl;
	stat_t  stat;

	logic [SUB_W-1:0] op_a;
	logic [SUB_W-1:0] op_b;
	logic [SUB_W-1:0] diff;
	logic             ge;
	logic [4:0]       mlen;
	logic [9:0]       y400_sum;
	logic             accept;

	assign in_year   = s_tdata[11:0];
	assign in_month  = s_tdata[15:12];
	assign in_day    = s_tdata[20:16];
	assign in_hour   = s_tdata[25:21];
	assign in_minute = s_tdata[31:26];
	assign in_second = s_tdata[37:32];
	assign in_th     = s_tdata[47:38];
	assign in_tm     = s_tdata[53:48];
	assign in_ts     = s_tdata[59:54];

	assign year_c = (in_year < YEAR_FIRST) ? YEAR_FIRST :
		(in_year > YEAR_LAST) ? YEAR_LAST : in_year;
	assign month_c = (in_month < MONTH_JAN) ? MONTH_JAN :
		(in_month > MONTH_DEC) ? MONTH_DEC : in_month;
	assign th_c = (17'(in_th) > 17'(MAX_TRIP_HOURS)) ? 10'(MAX_TRIP_HOURS) : in_th;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = ctrl.in_ready;

	assign mlen     = days_in(month_q, is_leap(y400_q));
	assign y400_sum = BASE_MOD + 10'(year_q - YEAR_FIRST);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (ctrl.op)
			OP_SEC: begin
				op_a = SUB_W'(sec_q);
				op_b = SEC_PER_MIN;
			end
			OP_MIN: begin
				op_a = SUB_W'(min_q);
				op_b = MIN_PER_HR;
			end
			OP_HOUR: begin
				op_a = hr_q;
				op_b = HR_PER_DAY << k_q;
			end
			OP_DAY: begin
				op_a = SUB_W'(day_q);
				op_b = SUB_W'(mlen);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	dtd_sub #(
		.W (SUB_W)
	) u_sub (
		.a    (op_a),
		.b    (op_b),
		.diff (diff),
		.ge   (ge)
	);

	assign stat.ge       = ge;
	assign stat.gt       = ge && (diff != '0);
	assign stat.ovf_next = stat.gt && (month_q == MONTH_DEC) && (year_q == YEAR_LAST);
	assign stat.bit_last = (k_q == 3'd0);
	assign stat.out_free = !m_tvalid_q || m_tready;

	dtd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_tvalid),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			year_q  <= year_c;
			month_q <= month_c;
			day_q   <= DAY_W'(in_day);
			sec_q   <= 7'(in_second) + 7'(in_ts);
			min_q   <= 8'(in_minute) + 8'(in_tm);
			hr_q    <= SUB_W'(in_hour) + SUB_W'(th_c);
			ovf_q   <= 1'b0;
		end
		if (ctrl.leap_ld) begin
			y400_q <= (y400_sum >= 10'd400) ? Y400_W'(y400_sum - 10'd400) : Y400_W'(y400_sum);
		end
		if (ctrl.clamp_ld) begin
			k_q <= 3'd5;
			if (day_q == '0) begin
				day_q <= DAY_W'(1);
			end else if (day_q > DAY_W'(mlen)) begin
				day_q <= DAY_W'(mlen);
			end
		end
		case (ctrl.op)
			OP_SEC: begin
				if (ge) begin
					sec_q <= diff[6:0];
					min_q <= min_q + 8'd1;
				end
			end
			OP_MIN: begin
				if (ge) begin
					min_q <= diff[7:0];
					hr_q  <= hr_q + SUB_W'(1);
				end
			end
			OP_HOUR: begin
				k_q <= k_q - 3'd1;
				if (ge) begin
					hr_q  <= diff;
					day_q <= day_q + (DAY_W'(1) << k_q);
				end
			end
			OP_DAY: begin
				if (stat.gt) begin
					day_q <= diff[DAY_W-1:0];
					if (month_q == MONTH_DEC) begin
						month_q <= MONTH_JAN;
						if (year_q == YEAR_LAST) begin
							ovf_q <= 1'b1;
						end else begin
							year_q <= year_q + 12'd1;
							y400_q <= (y400_q == Y400_LAST) ? '0 : y400_q + 9'd1;
						end
					end else begin
						month_q <= month_q + 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
		if (ctrl.out_ld) begin
			if (ovf_q) begin
				m_tdata_q <= {1'b0, 1'b1, SAT_SECOND, SAT_MINUTE, SAT_HOUR, SAT_DAY,
					MONTH_DEC, YEAR_LAST};
			end else begin
				m_tdata_q <= {1'b0, 1'b0, sec_q[5:0], min_q[5:0], hr_q[4:0],
					day_q[4:0], month_q, year_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- src/dtd_sub.sv -----
// ----------------------------------------------------------------------------
// dtd_sub
// shared subtract and compare unit used by every reduction step
// ----------------------------------------------------------------------------
module dtd_sub #(
	parameter int W = 11
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         ge
);

	assign diff = a - b;
	assign ge   = (a >= b);

endmodule

// ----- src/dtd_seq.sv -----
// ----------------------------------------------------------------------------
// dtd_seq
// sequencer stepping the shared unit through seconds, minutes, hours and days
// ----------------------------------------------------------------------------
module dtd_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	input  dtd_pkg::stat_t stat,
	output dtd_pkg::ctrl_t ctrl
);

	import dtd_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (s_valid) state_nx = S_LEAP;
			S_LEAP:  state_nx = S_CLAMP;
			S_CLAMP: state_nx = S_SEC;
			S_SEC:   if (!stat.ge) state_nx = S_MIN;
			S_MIN:   if (!stat.ge) state_nx = S_HOUR;
			S_HOUR:  if (stat.bit_last) state_nx = S_WALK;
			S_WALK:  if (!stat.gt || stat.ovf_next) state_nx = S_OUT;
			S_OUT:   if (stat.out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '{in_ready: 1'b0, leap_ld: 1'b0, clamp_ld: 1'b0, op: OP_NONE, out_ld: 1'b0};
		unique case (state_q)
			S_IDLE:  ctrl.in_ready = 1'b1;
			S_LEAP:  ctrl.leap_ld = 1'b1;
			S_CLAMP: ctrl.clamp_ld = 1'b1;
			S_SEC:   ctrl.op = OP_SEC;
			S_MIN:   ctrl.op = OP_MIN;
			S_HOUR:  ctrl.op = OP_HOUR;
			S_WALK:  ctrl.op = OP_DAY;
			S_OUT:   ctrl.out_ld = stat.out_free;
			default: ctrl.in_ready = 1'b0;
		endcase
	end

endmodule

// ----- src/dtd_check.sv -----
// ----------------------------------------------------------------------------
// dtd_check
// port-level checks on the date/time adder, bound to the top level
// ----------------------------------------------------------------------------
module dtd_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [dtd_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [dtd_pkg::OUT_W-1:0] m_tdata
);

	import dtd_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// block is busy right after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	// saturated result on overflow
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[38] |-> m_tdata[15:12] == MONTH_DEC &&
			m_tdata[20:16] == SAT_DAY && m_tdata[25:21] == SAT_HOUR &&
			m_tdata[31:26] == SAT_MINUTE && m_tdata[37:32] == SAT_SECOND)
		else $error("overflow word not saturated");

	// result hour, minute, second and month in calendar range, day nonzero
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:21] < 5'd24 && m_tdata[31:26] < 6'd60 &&
			m_tdata[37:32] < 6'd60 && m_tdata[15:12] >= MONTH_JAN &&
			m_tdata[15:12] <= MONTH_DEC && m_tdata[20:16] != 5'd0)
		else $error("output field out of range");

	// no result without a word in flight
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("output word appeared while idle");

endmodule

bind datetime_duration_adder dtd_check u_dtd_check (.*);
